### sv/bia_pkg.sv
// Package for the bottleneck information accumulator: word types, controller
// codes, the log2 table builder and the 48-bit saturation helper.
// No dependencies.
package bia_pkg;

   localparam int LOG_TABLE_BITS = 10;
   localparam int REM_BITS       = 31 - LOG_TABLE_BITS;
   localparam int TBL_N          = (1 << LOG_TABLE_BITS) + 1;

   typedef struct packed {
      logic [31:0] part_a_joint;
      logic [31:0] part_b_joint;
      logic [31:0] dest_marginal;
      logic [31:0] part_a_mass;
      logic [31:0] part_b_mass;
      logic        last;
   } bia_req_type;

   typedef struct packed {
      logic signed [47:0] group_info;
      logic signed [47:0] shared_info;
      logic signed [47:0] quality;
      logic               saturated;
   } bia_rsp_type;

   typedef struct packed {
      logic [31:0] tradeoff_weight;
      logic        use_tradeoff;
   } bia_cfg_type;

   typedef enum logic [0:0] {
      CSR_TRADEOFF_WEIGHT = 1'b0,
      CSR_USE_TRADEOFF    = 1'b1
   } bia_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ACC,
      ST_QMUL,
      ST_QFIN
   } bia_state_type;

   // one log2-and-scale evaluation walks through these steps
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_NORM,
      STEP_LOOK,
      STEP_INTP,
      STEP_MAG,
      STEP_MUL,
      STEP_TERM
   } bia_step_type;

   typedef enum logic [1:0] {
      SEL_GROUP,
      SEL_JOINT,
      SEL_MARG
   } bia_sel_type;

   typedef struct packed {
      logic         load;
      bia_step_type step;
      bia_sel_type  sel;
      logic         acc;
      logic         qmul;
      logic         qfin;
   } bia_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic rsp_busy;
   } bia_status_type;

   typedef logic [TBL_N-1:0][32:0] bia_tbl_type;

   // (z*z) >> 62
   function automatic logic [63:0] sq62(input logic [63:0] z);
      logic [127:0] p;
      p = {64'd0, z} * {64'd0, z};
      return p[125:62];
   endfunction

   // log2(z / 2^62) in Q0.32 for z in [2^62, 2^63), by repeated squaring
   function automatic logic [31:0] log_frac(input logic [63:0] z0);
      logic [63:0] z;
      logic [31:0] r;
      z = z0;
      r = '0;
      for (int k = 0; k < 32; k++) begin
         z = sq62(z);
         r = {r[30:0], 1'b0};
         if (z[63]) begin
            r[0] = 1'b1;
            z    = z >> 1;
         end
      end
      return r;
   endfunction

   function automatic bia_tbl_type build_tbl();
      bia_tbl_type t;
      for (int i = 0; i < TBL_N; i++) begin
         if (i == TBL_N - 1) begin
            t[i] = {1'b1, 32'd0};
         end else begin
            t[i] = {1'b0, log_frac((64'd1 << 62) +
                                   (64'(i) << (62 - LOG_TABLE_BITS)))};
         end
      end
      return t;
   endfunction

   localparam bia_tbl_type LOG_TBL = build_tbl();

   // clamp to signed 48 bits; bit 48 of the result flags a clamp
   function automatic logic [48:0] sat48(input logic signed [50:0] v);
      if (v > 51'sh7FFFFFFFFFFF) begin
         return {1'b1, 48'h7FFFFFFFFFFF};
      end else if (v < -51'sh800000000000) begin
         return {1'b1, 48'h800000000000};
      end
      return {1'b0, v[47:0]};
   endfunction

endpackage

### sv/bia_ctrl.sv
// Controller for the bottleneck information accumulator: sequences the
// log2/scale evaluations, accumulation and quality steps. Uses bia_pkg.
module bia_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bia_pkg::bia_status_type status,
   output bia_pkg::bia_cmd_type    cmd
);
   import bia_pkg::*;

   bia_state_type state_ff, state_in;
   bia_step_type  step_ff, step_in;
   bia_sel_type   sel_ff, sel_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_NONE;
         sel_ff   <= SEL_GROUP;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
      end
   end

   // advance the sequence
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      sel_in    = sel_ff;
      req_stall = 1'b1;
      cmd       = '{load: 1'b0, step: STEP_NONE, sel: sel_ff,
                    acc: 1'b0, qmul: 1'b0, qfin: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
               step_in  = STEP_NORM;
               sel_in   = status.first ? SEL_GROUP : SEL_JOINT;
            end
         end
         ST_EVAL: begin
            cmd.step = step_ff;
            unique case (step_ff)
               STEP_NORM: step_in = STEP_LOOK;
               STEP_LOOK: step_in = STEP_INTP;
               STEP_INTP: step_in = STEP_MAG;
               STEP_MAG:  step_in = STEP_MUL;
               STEP_MUL:  step_in = STEP_TERM;
               default: begin
                  step_in = STEP_NORM;
                  unique case (sel_ff)
                     SEL_GROUP: sel_in = SEL_JOINT;
                     SEL_JOINT: sel_in = SEL_MARG;
                     default: begin
                        state_in = ST_ACC;
                        step_in  = STEP_NONE;
                     end
                  endcase
               end
            endcase
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last ? ST_QMUL : ST_IDLE;
         end
         ST_QMUL: begin
            cmd.qmul = 1'b1;
            state_in = ST_QFIN;
         end
         default: begin
            if (!status.rsp_busy) begin
               cmd.qfin = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

endmodule

### sv/bia_datapath.sv
// Datapath for the bottleneck information accumulator: mass sums, shared
// log2/scale unit, accumulator, quality and result register. Uses bia_pkg.
module bia_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  bia_pkg::bia_cmd_type    cmd,
   input  bia_pkg::bia_req_type    req_data,
   input  bia_pkg::bia_cfg_type    cfg,
   output bia_pkg::bia_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bia_pkg::bia_rsp_type    rsp_data
);
   import bia_pkg::*;

   logic               first_ff, last_ff, flag_ff;
   logic [31:0]        pk_ff, pkj_ff, pj_ff;
   logic signed [47:0] group_ff, acc_ff;
   logic [37:0]        t1_ff, t2_ff;
   logic [4:0]         e_ff;
   logic [LOG_TABLE_BITS-1:0] idx_ff;
   logic [REM_BITS-1:0] rem_ff;
   logic               zero_ff;
   logic [32:0]        lo_ff, hi_ff, ip_ff;
   logic [37:0]        mag_ff;
   logic [37:0]        ph_ff;
   logic [63:0]        pl_ff;
   logic [63:0]        qh_ff, ql_ff;
   logic               rsp_valid_ff;
   bia_rsp_type        rsp_ff;

   logic [32:0] pk_sum, pkj_sum;
   logic [31:0] opnd, scl, m_norm;
   logic [4:0]  e_val;
   logic [33:0] frac;
   logic [38:0] term_val;
   logic signed [50:0] acc_sum;
   logic [48:0] acc_sat;
   logic [47:0] amag;
   logic [64:0] prod;
   logic [48:0] prod_c;
   logic        prod_f;
   logic signed [50:0] qv;
   logic [48:0] q_sat;

   assign pk_sum  = {1'b0, req_data.part_a_mass} + {1'b0, req_data.part_b_mass};
   assign pkj_sum = {1'b0, req_data.part_a_joint} + {1'b0, req_data.part_b_joint};

   // pick log operand and scale factor
   always_comb begin
      unique case (cmd.sel)
         SEL_GROUP: opnd = pk_ff;
         SEL_JOINT: opnd = pkj_ff;
         default:   opnd = pj_ff;
      endcase
      scl = (cmd.sel == SEL_GROUP) ? pk_ff : pkj_ff;
   end

   // find leading one and normalize
   always_comb begin
      e_val = '0;
      for (int b = 1; b < 32; b++) begin
         if (opnd[b]) e_val = 5'(b);
      end
      m_norm = opnd << (5'd31 - e_val);
   end

   assign frac     = {1'b0, lo_ff} + {1'b0, ip_ff};
   assign term_val = {1'b0, ph_ff} + {7'd0, pl_ff[63:32]};
   assign acc_sum  = 51'(acc_ff) + 51'(signed'({1'b0, t2_ff})) -
                     51'(signed'({1'b0, t1_ff}));
   assign acc_sat  = sat48(acc_sum);
   assign amag     = acc_ff[47] ? 48'(-acc_ff) : 48'(acc_ff);

   // weighted shared term, clamped at 2^48, and the saturated quality
   always_comb begin
      prod   = 65'(qh_ff) + 65'(ql_ff >> 16);
      prod_f = 1'b0;
      prod_c = prod[48:0];
      if (qh_ff > 64'hFFFFFFFFFFFF || prod > 65'h1000000000000) begin
         prod_f = 1'b1;
         prod_c = 49'h1000000000000;
      end
      if (!cfg.use_tradeoff) begin
         qv = -51'(acc_ff);
      end else if (acc_ff[47]) begin
         qv = 51'(group_ff) + 51'(prod_c);
      end else begin
         qv = 51'(group_ff) - 51'(prod_c);
      end
      q_sat = sat48(qv);
   end

   // run control state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         flag_ff      <= 1'b0;
         group_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            flag_ff <= (first_ff ? (pk_sum[32] | pkj_sum[32]) : flag_ff) | pkj_sum[32];
         end
         if (cmd.step == STEP_TERM && cmd.sel == SEL_GROUP) begin
            group_ff <= zero_ff ? '0 : 48'(term_val);
            acc_ff   <= zero_ff ? '0 : 48'(term_val);
         end
         if (cmd.acc) begin
            acc_ff  <= acc_sat[47:0];
            flag_ff <= flag_ff | acc_sat[48];
            if (!last_ff) first_ff <= 1'b0;
         end
         if (cmd.qfin) begin
            first_ff <= 1'b1;
         end
         // drop word once taken; a new result wins
         if (cmd.qfin) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pk_ff   <= pk_sum[32] ? 32'hFFFFFFFF : pk_sum[31:0];
         pkj_ff  <= pkj_sum[32] ? 32'hFFFFFFFF : pkj_sum[31:0];
         pj_ff   <= req_data.dest_marginal;
         last_ff <= req_data.last;
      end
      unique case (cmd.step)
         STEP_NORM: begin
            e_ff    <= e_val;
            idx_ff  <= m_norm[30:REM_BITS];
            rem_ff  <= m_norm[REM_BITS-1:0];
            zero_ff <= (opnd == '0);
         end
         STEP_LOOK: begin
            lo_ff <= LOG_TBL[idx_ff];
            hi_ff <= LOG_TBL[{1'b0, idx_ff} + (LOG_TABLE_BITS+1)'(1)];
         end
         STEP_INTP: begin
            ip_ff <= 33'(((hi_ff - lo_ff) * {{33{1'b0}}, rem_ff}) >> REM_BITS);
         end
         STEP_MAG: begin
            mag_ff <= {6'd32 - {1'b0, e_ff}, 32'd0} - {4'd0, frac};
         end
         STEP_MUL: begin
            ph_ff <= {6'd0, scl} * {32'd0, mag_ff[37:32]};
            pl_ff <= {32'd0, scl} * {32'd0, mag_ff[31:0]};
         end
         STEP_TERM: begin
            if (cmd.sel == SEL_JOINT) t1_ff <= zero_ff ? '0 : term_val[37:0];
            if (cmd.sel == SEL_MARG)  t2_ff <= zero_ff ? '0 : term_val[37:0];
         end
         default: begin
         end
      endcase
      if (cmd.qmul) begin
         qh_ff <= {48'd0, cfg.tradeoff_weight[31:16]} * {16'd0, amag};
         ql_ff <= {48'd0, cfg.tradeoff_weight[15:0]} * {16'd0, amag};
      end
      if (cmd.qfin) begin
         rsp_ff.group_info  <= group_ff;
         rsp_ff.shared_info <= acc_ff;
         rsp_ff.quality     <= q_sat[47:0];
         rsp_ff.saturated   <= flag_ff | q_sat[48] |
                               (cfg.use_tradeoff & prod_f);
      end
   end

   assign status.first    = first_ff;
   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff & rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

### sv/bottleneck_information_accumulator.sv
// Top level of the bottleneck information accumulator: configuration
// registers, controller and datapath. Uses bia_pkg, bia_ctrl, bia_datapath.
//
//   channel  direction  handshake        word
//   req_     in         valid / stall    bia_req_type
//   rsp_     out        valid / stall    bia_rsp_type
//   csr_     in         valid / ready    index + 32-bit data
//
// Each item runs the shared log2/scale unit for its joint and marginal terms,
// with one extra evaluation for the group term on the first item of a run
// (six steps each), then accumulates; the last item adds the quality product.
// The single log2/scale unit sets the pace.
// Reset is synchronous and active high; no clearing pass.
// req_stall is high from an accept until the item is done. A result is held
// in an output register; the quality step waits while the previous result
// is still stalled.
module bottleneck_information_accumulator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bia_pkg::bia_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bia_pkg::bia_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import bia_pkg::*;

   bia_cfg_type    cfg_ff;
   bia_cmd_type    cmd;
   bia_status_type status;

   assign csr_ready = 1'b1;

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tradeoff_weight <= '0;
         cfg_ff.use_tradeoff    <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TRADEOFF_WEIGHT: cfg_ff.tradeoff_weight <= csr_wdata;
            default:             cfg_ff.use_tradeoff    <= csr_wdata[0];
         endcase
      end
   end

   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bia_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted word did not start work");

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> req_valid && !req_stall)
      else $error("load without accepted word");

   a_rsp_from_qfin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.qfin))
      else $error("result shown without quality step");

endmodule

### tb/tb_top.sv
// Testbench for the bottleneck information accumulator: drives runs of words
// with bursty sending and a stalling receiver, predicts each result in place.
// Depends on bia_pkg and bottleneck_information_accumulator.
`timescale 1ns / 100ps

module tb_top;
   import bia_pkg::*;

   localparam int TB_BITS   = 10;
   localparam int TB_REM    = 31 - TB_BITS;
   localparam int TB_N      = (1 << TB_BITS) + 1;
   localparam int DRAIN_CYC = 40;
   localparam int MAX_CYC   = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bia_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bia_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   bottleneck_information_accumulator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bia_req_type pending_words[$];
   bia_rsp_type expected_scores[$];
   int          error_count = 0;
   int          cycle_count = 0;

   // shadow of the block's registers and run state
   logic [31:0] weight_q = 32'd0;
   logic        tradeoff_on = 1'b1;
   longint      grp_entropy = 0;
   longint      shared_acc = 0;
   logic        run_start = 1'b1;
   logic        run_flag = 1'b0;
   logic [32:0] log_lut[TB_N];

   // build log2(1 + i/2^T) by repeated squaring
   function automatic logic [31:0] frac_log2(input logic [63:0] z0);
      logic [127:0] sq;
      logic [63:0]  z;
      logic [31:0]  r;
      z = z0;
      r = '0;
      repeat (32) begin
         sq = {64'd0, z} * {64'd0, z};
         z  = sq[125:62];
         r  = r << 1;
         if (z[63]) begin
            r[0] = 1'b1;
            z    = z >> 1;
         end
      end
      return r;
   endfunction

   // |log2(x / 2^32)| in Q.32, x nonzero
   function automatic logic [63:0] abs_log2(input logic [31:0] x);
      int          msb;
      logic [31:0] m;
      logic [30:0] f;
      logic [63:0] idx, rem, lo, hi, frac;
      msb = 31;
      while (msb > 0 && !x[msb]) msb--;
      m    = x << (31 - msb);
      f    = m[30:0];
      idx  = 64'(f >> TB_REM);
      rem  = 64'(f) & ((64'd1 << TB_REM) - 1);
      lo   = 64'(log_lut[idx]);
      hi   = 64'(log_lut[idx + 1]);
      frac = lo + (((hi - lo) * rem) >> TB_REM);
      return (64'(32 - msb) << 32) - frac;
   endfunction

   function automatic longint weigh(input logic [31:0] q, input logic [63:0] mag);
      logic [63:0] qq;
      qq = 64'(q);
      return longint'(qq * (mag >> 32) + ((qq * (mag & 64'hFFFFFFFF)) >> 32));
   endfunction

   function automatic longint clamp48(input longint v, inout logic fl);
      if (v > 64'sh7FFFFFFFFFFF) begin
         fl = 1'b1;
         return 64'sh7FFFFFFFFFFF;
      end
      if (v < -64'sh800000000000) begin
         fl = 1'b1;
         return -64'sh800000000000;
      end
      return v;
   endfunction

   function automatic logic [31:0] mass_sum(input logic [31:0] a, input logic [31:0] b,
                                           inout logic fl);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[32]) begin
         fl = 1'b1;
         return 32'hFFFFFFFF;
      end
      return s[31:0];
   endfunction

   // advance the run state by one word; queue a score on the last one
   task automatic score_word(input bia_req_type w);
      logic        fl;
      logic [31:0] pk, pkj;
      longint      term, qv, sum;
      logic [63:0] mag, prod, lim;
      bia_rsp_type r;
      fl   = 1'b0;
      term = 0;
      lim  = 64'h1000000000000;
      if (run_start) begin
         pk          = mass_sum(w.part_a_mass, w.part_b_mass, fl);
         run_flag    = 1'b0;
         grp_entropy = (pk != 0) ? weigh(pk, abs_log2(pk)) : 0;
         shared_acc  = grp_entropy;
      end
      pkj = mass_sum(w.part_a_joint, w.part_b_joint, fl);
      if (pkj != 0) term -= weigh(pkj, abs_log2(pkj));
      if (w.dest_marginal != 0) term += weigh(pkj, abs_log2(w.dest_marginal));
      shared_acc = clamp48(shared_acc + term, fl);
      if (!w.last) begin
         run_flag  = run_flag | fl;
         run_start = 1'b0;
         return;
      end
      if (!tradeoff_on) begin
         qv = clamp48(-shared_acc, fl);
      end else begin
         mag  = (shared_acc < 0) ? 64'(-shared_acc) : 64'(shared_acc);
         prod = 64'(weight_q[31:16]) * mag;
         if (prod > lim - 1) begin
            fl   = 1'b1;
            prod = lim;
         end else begin
            prod += (64'(weight_q[15:0]) * mag) >> 16;
         end
         if (prod > lim) begin
            fl   = 1'b1;
            prod = lim;
         end
         sum = (shared_acc < 0) ? grp_entropy + longint'(prod)
                                : grp_entropy - longint'(prod);
         qv  = clamp48(sum, fl);
      end
      run_flag      = run_flag | fl;
      r.group_info  = grp_entropy[47:0];
      r.shared_info = shared_acc[47:0];
      r.quality     = qv[47:0];
      r.saturated   = run_flag;
      expected_scores.push_back(r);
      run_start = 1'b1;
   endtask

   // sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) score_word(req_data);
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern in modes, one with no stalls at all
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(5, 120);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // check each accepted score against the oldest prediction
   always @(posedge clock) begin
      bia_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scores.size() == 0) begin
            $error("unexpected score word %h", rsp_data);
            error_count++;
         end else begin
            e = expected_scores.pop_front();
            if (rsp_data.group_info !== e.group_info) begin
               $error("group_info exp %0d got %0d", e.group_info, rsp_data.group_info);
               error_count++;
            end
            if (rsp_data.shared_info !== e.shared_info) begin
               $error("shared_info exp %0d got %0d", e.shared_info, rsp_data.shared_info);
               error_count++;
            end
            if (rsp_data.quality !== e.quality) begin
               $error("quality exp %0d got %0d", e.quality, rsp_data.quality);
               error_count++;
            end
            if (rsp_data.saturated !== e.saturated) begin
               $error("saturated exp %0d got %0d", e.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYC) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic logic [31:0] any32();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFFFFFF;
         2: return $urandom;
         3: return $urandom >> $urandom_range(0, 31);
         4: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   // probability-like mass, mostly without overflow on the sum
   function automatic logic [31:0] prob32();
      if ($urandom_range(0, 9) == 0) return any32();
      return $urandom >> $urandom_range(1, 12);
   endfunction

   task automatic push_word(input logic [31:0] aj, input logic [31:0] bj,
                            input logic [31:0] mg, input logic [31:0] am,
                            input logic [31:0] bm, input logic lst);
      bia_req_type w;
      w.part_a_joint  = aj;
      w.part_b_joint  = bj;
      w.dest_marginal = mg;
      w.part_a_mass   = am;
      w.part_b_mass   = bm;
      w.last          = lst;
      pending_words.push_back(w);
   endtask

   task automatic csr_write(input bia_csr_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TRADEOFF_WEIGHT) weight_q = data;
      else tradeoff_on = data[0];
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_scores.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic random_runs(input int n_words);
      int sent, len;
      sent = 0;
      while (sent < n_words) begin
         len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
         for (int k = 0; k < len; k++)
            push_word(prob32(), prob32(), prob32(), prob32(), prob32(), k == len - 1);
         sent += len;
      end
   endtask

   initial begin
      logic [31:0] wsets[5];
      logic        usets[5];
      for (int i = 0; i < TB_N; i++)
         log_lut[i] = (i == TB_N - 1) ? {1'b1, 32'd0}
                    : {1'b0, frac_log2((64'd1 << 62) + (64'(i) << (62 - TB_BITS)))};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wsets = '{32'h00010000, 32'hFFFFFFFF, 32'd0, $urandom, $urandom};
      usets = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CSR_TRADEOFF_WEIGHT, wsets[ph]);
         csr_write(CSR_USE_TRADEOFF, {31'd0, usets[ph]});
         if (ph < 2) begin
            // single-item runs: all zero, all ones, smallest masses
            push_word(0, 0, 0, 0, 0, 1);
            push_word('1, '1, '1, '1, '1, 1);
            push_word(1, 0, 1, 1, 0, 1);
            // zero joint, zero marginal, then a joint sum overflow on the last word
            push_word(0, 0, 32'h40000000, 32'h20000000, 32'h20000000, 0);
            push_word(32'h10000000, 32'h10000000, 0, 0, 0, 0);
            push_word('1, 32'h1, 32'h1, 0, 0, 1);
            // flag is cleared for the next run
            push_word(32'h08000000, 32'h08000000, 32'h20000000, 32'h40000000, 0, 1);
            // long run of large terms drives the shared sum
            for (int k = 0; k < 12; k++)
               push_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, '1, 0, k == 11);
         end
         random_runs(250);
         drain();
      end

      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
